// ----- sv/smcrq_pkg.sv -----
// ----------------------------------------------------------------------------
// smcrq_pkg
// Shared types, widths and codes of the memory channel request queue.
// ----------------------------------------------------------------------------
package smcrq_pkg;

    // Field widths
    localparam int SIZE_W  = 48;
    localparam int REQ_W   = 8;
    localparam int TAG_W   = 16;
    localparam int RT_W    = 64;
    localparam int LAT_W   = 32;
    localparam int BW_W    = 16;
    localparam int PER_W   = 9;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // Bytes per gigabyte and its width
    localparam longint unsigned BYTES_PER_GB = 64'd1000000000;
    localparam int GB_W = 30;

    // Size is multiplied in chunks, most significant first
    localparam int CHUNK_W = 16;
    localparam int NCHUNK  = (SIZE_W + CHUNK_W - 1) / CHUNK_W;

    // Parameter defaults
    localparam int              NODES_DEF       = 8;
    localparam int              QUEUE_DEPTH_DEF = 16;
    localparam longint unsigned CLOCK_HZ_DEF    = 64'd1000000000;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_NODE = 2'd1,
        MODE_NPU  = 2'd2,
        MODE_POOL = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_REMOTE  = 2'd1,
        ST_QUEUE_FULL = 2'd2,
        ST_NODE_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        OP_REQUEST  = 1'b0,
        OP_COMPLETE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_MODE = 3'd0,
        REG_PER  = 3'd1,
        REG_LLAT = 3'd2,
        REG_LBW  = 3'd3,
        REG_RLAT = 3'd4,
        REG_RBW  = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NODE_DIV,
        S_NODE_CHK,
        S_POP_RD,
        S_POP_WB,
        S_MUL,
        S_DIV
    } t_state;

    typedef struct packed {
        t_mode             mode;
        logic [PER_W-1:0]  per;
        logic [LAT_W-1:0]  llat;
        logic [BW_W-1:0]   lbw;
        logic [LAT_W-1:0]  rlat;
        logic [BW_W-1:0]   rbw;
    } t_cfg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    node_start;
        logic    ch_latch;
        logic    div_run;
        logic    enqueue;
        logic    claim_ch;
        logic    free_ch;
        logic    pop_rd;
        logic    pop_wb;
        logic    mul_start;
        logic    use_remote;
        logic    hold;
        logic    mul_run;
        logic    quo_start;
        logic    emit_time;
        logic    emit_err;
        t_status err_code;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_op   op;
        logic  is_remote;
        t_mode mode;
        logic  div_done;
        logic  mul_done;
        logic  oor;
        logic  ch_busy;
        logic  q_full;
        logic  q_empty;
    } t_stat;

endpackage

// ----- sv/smcrq_regs.sv -----
// ----------------------------------------------------------------------------
// smcrq_regs
// APB configuration registers with readback.
// ----------------------------------------------------------------------------
module smcrq_regs
    import smcrq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign o_cfg  = r_cfg;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_NONE;
            r_cfg.per  <= PER_W'(1);
            r_cfg.llat <= '0;
            r_cfg.lbw  <= BW_W'(1);
            r_cfg.rlat <= '0;
            r_cfg.rbw  <= BW_W'(1);
        end else if (wr_en) begin
            case (idx)
                REG_MODE: r_cfg.mode <= t_mode'(pwdata[1:0]);
                REG_PER:  r_cfg.per  <= pwdata[PER_W-1:0];
                REG_LLAT: r_cfg.llat <= pwdata[LAT_W-1:0];
                REG_LBW:  r_cfg.lbw  <= pwdata[BW_W-1:0];
                REG_RLAT: r_cfg.rlat <= pwdata[LAT_W-1:0];
                REG_RBW:  r_cfg.rbw  <= pwdata[BW_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (idx)
            REG_MODE: prdata = APB_DW'(r_cfg.mode);
            REG_PER:  prdata = APB_DW'(r_cfg.per);
            REG_LLAT: prdata = APB_DW'(r_cfg.llat);
            REG_LBW:  prdata = APB_DW'(r_cfg.lbw);
            REG_RLAT: prdata = APB_DW'(r_cfg.rlat);
            REG_RBW:  prdata = APB_DW'(r_cfg.rbw);
            default:  prdata = '0;
        endcase
    end

endmodule

// ----- sv/smcrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// smcrq_ctrl
// Sequencer: decodes each word, walks node lookup, queue and timing steps.
// ----------------------------------------------------------------------------
module smcrq_ctrl
    import smcrq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.op == OP_REQUEST) begin
                    if (!i_stat.is_remote) begin
                        n_state = S_MUL;
                    end else begin
                        case (i_stat.mode)
                            MODE_NONE: n_state = S_IDLE;
                            MODE_NPU:  n_state = S_MUL;
                            MODE_NODE: n_state = S_NODE_DIV;
                            MODE_POOL: n_state = S_NODE_CHK;
                            default:   n_state = S_IDLE;
                        endcase
                    end
                end else begin
                    case (i_stat.mode)
                        MODE_NODE: n_state = S_NODE_DIV;
                        MODE_POOL: n_state = S_NODE_CHK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_NODE_DIV: begin
                if (i_stat.div_done) n_state = S_NODE_CHK;
            end
            S_NODE_CHK: begin
                if (i_stat.oor) begin
                    n_state = S_IDLE;
                end else if (i_stat.op == OP_REQUEST) begin
                    n_state = i_stat.ch_busy ? S_IDLE : S_MUL;
                end else begin
                    n_state = i_stat.q_empty ? S_IDLE : S_POP_RD;
                end
            end
            S_POP_RD: n_state = S_POP_WB;
            S_POP_WB: n_state = S_MUL;
            S_MUL: begin
                if (i_stat.mul_done) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.err_code = ST_OK;
        busy           = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_DECODE: begin
                if (i_stat.op == OP_REQUEST) begin
                    if (!i_stat.is_remote) begin
                        o_cmd.mul_start = 1'b1;
                    end else begin
                        case (i_stat.mode)
                            MODE_NONE: begin
                                o_cmd.emit_err = 1'b1;
                                o_cmd.err_code = ST_NO_REMOTE;
                            end
                            MODE_NPU: begin
                                o_cmd.mul_start  = 1'b1;
                                o_cmd.use_remote = 1'b1;
                            end
                            MODE_NODE: o_cmd.node_start = 1'b1;
                            MODE_POOL: o_cmd.ch_latch   = 1'b1;
                            default: ;
                        endcase
                    end
                end else begin
                    case (i_stat.mode)
                        MODE_NODE: o_cmd.node_start = 1'b1;
                        MODE_POOL: o_cmd.ch_latch   = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_NODE_DIV: begin
                if (i_stat.div_done) o_cmd.ch_latch = 1'b1;
                else                 o_cmd.div_run  = 1'b1;
            end
            S_NODE_CHK: begin
                if (i_stat.op == OP_REQUEST) begin
                    if (i_stat.oor) begin
                        o_cmd.emit_err = 1'b1;
                        o_cmd.err_code = ST_NODE_RANGE;
                    end else if (i_stat.ch_busy) begin
                        if (i_stat.q_full) begin
                            o_cmd.emit_err = 1'b1;
                            o_cmd.err_code = ST_QUEUE_FULL;
                        end else begin
                            o_cmd.enqueue = 1'b1;
                        end
                    end else begin
                        o_cmd.claim_ch   = 1'b1;
                        o_cmd.mul_start  = 1'b1;
                        o_cmd.use_remote = 1'b1;
                        o_cmd.hold       = 1'b1;
                    end
                end else if (!i_stat.oor) begin
                    if (i_stat.q_empty) o_cmd.free_ch = 1'b1;
                    else                o_cmd.pop_rd  = 1'b1;
                end
            end
            S_POP_RD: ;
            S_POP_WB: begin
                o_cmd.pop_wb     = 1'b1;
                o_cmd.mul_start  = 1'b1;
                o_cmd.use_remote = 1'b1;
                o_cmd.hold       = 1'b1;
            end
            S_MUL: begin
                if (i_stat.mul_done) o_cmd.quo_start = 1'b1;
                else                 o_cmd.mul_run   = 1'b1;
            end
            S_DIV: begin
                if (i_stat.div_done) o_cmd.emit_time = 1'b1;
                else                 o_cmd.div_run   = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/smcrq_dp.sv -----
// ----------------------------------------------------------------------------
// smcrq_dp
// Datapath: item registers, chunked multiplier, shared restoring divider,
// per-channel queue pointers, waiting-request memory and result registers.
// ----------------------------------------------------------------------------
module smcrq_dp
    import smcrq_pkg::*;
#(
    parameter int              NODES       = NODES_DEF,
    parameter int              QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter longint unsigned CLOCK_HZ    = CLOCK_HZ_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_op,
    input  logic              i_is_remote,
    input  logic [REQ_W-1:0]  i_requester,
    input  logic [SIZE_W-1:0] i_tensor_size,
    input  logic [TAG_W-1:0]  i_tag,
    output logic              o_result_valid,
    output logic [REQ_W-1:0]  o_dest_requester,
    output logic [TAG_W-1:0]  o_dest_tag,
    output logic [RT_W-1:0]   o_runtime,
    output logic              o_holds_channel,
    output logic [1:0]        o_status
);

    localparam int CLK_W  = $clog2(CLOCK_HZ + 1);
    localparam int PP_W   = CHUNK_W + CLK_W;
    localparam int PROD_W = SIZE_W + CLK_W;
    localparam int DIV_W  = BW_W + GB_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int MCNT_W = $clog2(NCHUNK + 1);
    localparam int CH_W   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int CQ_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CQ_W + 1;
    localparam int SLOTS  = NODES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int ENT_W  = SIZE_W + REQ_W + TAG_W;
    localparam logic [CLK_W-1:0] CLK_C = CLK_W'(CLOCK_HZ);

    // Item registers
    t_op               r_op;
    logic              r_remote;
    logic [REQ_W-1:0]  r_req;
    logic [SIZE_W-1:0] r_size;
    logic [TAG_W-1:0]  r_tag;

    // Multiplier
    logic [SIZE_W-1:0] r_mul_sz;
    logic [PROD_W-1:0] r_prod;
    logic [MCNT_W-1:0] r_mcnt;
    logic              r_use_remote;
    logic              r_hold;
    logic [PP_W-1:0]   pp;

    // Divider
    logic [PROD_W-1:0] r_dvd;
    logic [PROD_W-1:0] r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsr;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W:0]    rem_sh;
    logic              q_bit;
    logic [DIV_W-1:0]  rem_next;
    logic [BW_W-1:0]   bw_c;
    logic [PER_W-1:0]  per_c;
    logic [DIV_W-1:0]  bw_bytes;

    // Channel state
    logic [CH_W-1:0]   r_ch;
    logic              r_oor;
    logic              r_busy  [NODES];
    logic [QIDX_W-1:0] r_head  [NODES];
    logic [CQ_W-1:0]   r_count [NODES];
    logic [REQ_W-1:0]  node_val;
    logic              node_oor;
    logic              sel_busy;
    logic [QIDX_W-1:0] sel_head;
    logic [CQ_W-1:0]   sel_count;
    logic [SUM_W-1:0]  tail_sum;
    logic [QIDX_W-1:0] tail;
    logic [QIDX_W-1:0] head_next;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Waiting-request memory
    logic [ENT_W-1:0]  r_mem [SLOTS];
    logic [ENT_W-1:0]  r_rd_data;
    logic [SIZE_W-1:0] rd_size;
    logic [REQ_W-1:0]  rd_req;
    logic [TAG_W-1:0]  rd_tag;

    // Result finish
    logic [PROD_W+RT_W-1:0] quo_x;
    logic                   quo_over;
    logic [RT_W:0]          rt_sum;
    logic [LAT_W-1:0]       lat_sel;
    logic [RT_W-1:0]        rt_final;

    // Result registers
    logic              r_out_valid;
    logic [REQ_W-1:0]  r_out_req;
    logic [TAG_W-1:0]  r_out_tag;
    logic [RT_W-1:0]   r_out_rt;
    logic              r_out_hold;
    t_status           r_out_status;

    // Clamp zero operands
    assign per_c    = (i_cfg.per == '0) ? PER_W'(1) : i_cfg.per;
    assign bw_c     = r_use_remote ? ((i_cfg.rbw == '0) ? BW_W'(1) : i_cfg.rbw)
                                   : ((i_cfg.lbw == '0) ? BW_W'(1) : i_cfg.lbw);
    assign bw_bytes = DIV_W'(bw_c) * DIV_W'(BYTES_PER_GB);

    // Capture the word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_op);
            r_remote <= i_is_remote;
            r_req    <= i_requester;
            r_size   <= i_tensor_size;
            r_tag    <= i_tag;
        end else if (i_cmd.pop_wb) begin
            r_req    <= rd_req;
            r_size   <= rd_size;
            r_tag    <= rd_tag;
        end
    end

    // Multiply size by clock rate, one chunk a cycle
    assign pp = PP_W'(r_mul_sz[SIZE_W-1 -: CHUNK_W]) * PP_W'(CLK_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (i_cmd.mul_start) begin
            r_mcnt <= '0;
        end else if (i_cmd.mul_run) begin
            r_mcnt <= r_mcnt + MCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mul_sz     <= i_cmd.pop_wb ? rd_size : r_size;
            r_prod       <= '0;
            r_use_remote <= i_cmd.use_remote;
            r_hold       <= i_cmd.hold;
        end else if (i_cmd.mul_run) begin
            r_prod   <= (r_prod << CHUNK_W) + PROD_W'(pp);
            r_mul_sz <= r_mul_sz << CHUNK_W;
        end
    end

    // Restoring divider, one quotient bit a cycle
    assign rem_sh   = {r_rem, r_dvd[PROD_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_dsr});
    assign rem_next = q_bit ? DIV_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[DIV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.node_start) begin
            r_cnt <= CNT_W'(REQ_W);
        end else if (i_cmd.quo_start) begin
            r_cnt <= CNT_W'(PROD_W);
        end else if (i_cmd.div_run) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.node_start) begin
            r_dvd <= {r_req, {(PROD_W-REQ_W){1'b0}}};
            r_dsr <= DIV_W'(per_c);
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.quo_start) begin
            r_dvd <= r_prod;
            r_dsr <= bw_bytes;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_run) begin
            r_dvd <= r_dvd << 1;
            r_rem <= rem_next;
            r_quo <= {r_quo[PROD_W-2:0], q_bit};
        end
    end

    // Node index from quotient
    assign node_val = r_quo[REQ_W-1:0];
    assign node_oor = ({1'b0, node_val} >= (REQ_W+1)'(NODES));

    // Selected channel view
    assign sel_busy  = r_busy[r_ch];
    assign sel_head  = r_head[r_ch];
    assign sel_count = r_count[r_ch];
    assign tail_sum  = SUM_W'(sel_head) + SUM_W'(sel_count);
    assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                     ? QIDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QIDX_W'(tail_sum);
    assign head_next = (sel_head == QIDX_W'(QUEUE_DEPTH - 1))
                     ? '0 : sel_head + QIDX_W'(1);
    assign wr_addr   = ADDR_W'(r_ch) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail);
    assign rd_addr   = ADDR_W'(r_ch) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(sel_head);

    // Latch channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch  <= '0;
            r_oor <= 1'b0;
        end else if (i_cmd.ch_latch) begin
            if (i_cfg.mode == MODE_POOL) begin
                r_ch  <= '0;
                r_oor <= 1'b0;
            end else begin
                r_ch  <= node_oor ? '0 : CH_W'(node_val);
                r_oor <= node_oor;
            end
        end
    end

    // Update busy flags and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NODES; n++) begin
                r_busy[n]  <= 1'b0;
                r_head[n]  <= '0;
                r_count[n] <= '0;
            end
        end else begin
            if (i_cmd.claim_ch) r_busy[r_ch] <= 1'b1;
            if (i_cmd.free_ch)  r_busy[r_ch] <= 1'b0;
            if (i_cmd.enqueue)  r_count[r_ch] <= sel_count + CQ_W'(1);
            if (i_cmd.pop_wb) begin
                r_head[r_ch]  <= head_next;
                r_count[r_ch] <= sel_count - CQ_W'(1);
                r_busy[r_ch]  <= 1'b1;
            end
        end
    end

    // Waiting-request memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.enqueue) r_mem[wr_addr] <= {r_size, r_req, r_tag};
        if (i_cmd.pop_rd)  r_rd_data <= r_mem[rd_addr];
    end

    assign rd_size = r_rd_data[ENT_W-1 -: SIZE_W];
    assign rd_req  = r_rd_data[TAG_W +: REQ_W];
    assign rd_tag  = r_rd_data[TAG_W-1:0];

    // Saturate quotient and add latency
    assign quo_x    = {{RT_W{1'b0}}, r_quo};
    assign quo_over = |quo_x[PROD_W+RT_W-1:RT_W];
    assign lat_sel  = r_use_remote ? i_cfg.rlat : i_cfg.llat;
    assign rt_sum   = {1'b0, quo_x[RT_W-1:0]} + (RT_W+1)'(lat_sel);
    assign rt_final = (quo_over || rt_sum[RT_W]) ? {RT_W{1'b1}} : rt_sum[RT_W-1:0];

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit_time | i_cmd.emit_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_time) begin
            r_out_req    <= r_req;
            r_out_tag    <= r_tag;
            r_out_rt     <= rt_final;
            r_out_hold   <= r_hold;
            r_out_status <= ST_OK;
        end else if (i_cmd.emit_err) begin
            r_out_req    <= r_req;
            r_out_tag    <= r_tag;
            r_out_rt     <= '0;
            r_out_hold   <= 1'b0;
            r_out_status <= i_cmd.err_code;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_dest_requester = r_out_req;
    assign o_dest_tag       = r_out_tag;
    assign o_runtime        = r_out_rt;
    assign o_holds_channel  = r_out_hold;
    assign o_status         = r_out_status;

    // Status to the controller
    assign o_stat.op        = r_op;
    assign o_stat.is_remote = r_remote;
    assign o_stat.mode      = i_cfg.mode;
    assign o_stat.div_done  = (r_cnt == '0);
    assign o_stat.mul_done  = (r_mcnt == MCNT_W'(NCHUNK));
    assign o_stat.oor       = r_oor;
    assign o_stat.ch_busy   = sel_busy;
    assign o_stat.q_full    = (sel_count >= CQ_W'(QUEUE_DEPTH));
    assign o_stat.q_empty   = (sel_count == '0);

endmodule

// ----- sv/shared_memory_channel_request_queue_core.sv -----
// ----------------------------------------------------------------------------
// shared_memory_channel_request_queue_core
// Memory access timing with per-node or pooled channel serialization.
// A timed result passes the chunked multiplier, then the restoring divider;
//   per-node lookups first add a divider pass and a channel check, a pool lookup
//   adds the channel check alone and a queue pop adds a memory read and a write-back.
// Error results come from decode or the channel check; queued and ignored words
//   give no result. Throughput: one word at a time, busy high until done.
// Reset (synchronous): clears configuration, busy flags and queue pointers;
//   the waiting-request memory is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module shared_memory_channel_request_queue_core
    import smcrq_pkg::*;
#(
    parameter int              NODES       = NODES_DEF,
    parameter int              QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter longint unsigned CLOCK_HZ    = CLOCK_HZ_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic              i_op,
    input  logic              i_is_remote,
    input  logic [REQ_W-1:0]  i_requester,
    input  logic [SIZE_W-1:0] i_tensor_size,
    input  logic [TAG_W-1:0]  i_tag,
    output logic              o_result_valid,
    output logic [REQ_W-1:0]  o_dest_requester,
    output logic [TAG_W-1:0]  o_dest_tag,
    output logic [RT_W-1:0]   o_runtime,
    output logic              o_holds_channel,
    output logic [1:0]        o_status
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    // Configuration registers
    smcrq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    smcrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath
    smcrq_dp #(
        .NODES       (NODES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CLOCK_HZ    (CLOCK_HZ)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_op),
        .i_is_remote      (i_is_remote),
        .i_requester      (i_requester),
        .i_tensor_size    (i_tensor_size),
        .i_tag            (i_tag),
        .o_result_valid   (o_result_valid),
        .o_dest_requester (o_dest_requester),
        .o_dest_tag       (o_dest_tag),
        .o_runtime        (o_runtime),
        .o_holds_channel  (o_holds_channel),
        .o_status         (o_status)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the memory channel request queue against a cycle-free predictor:
// directed corner words, then random request/completion traffic in several
// configurations, with random start gaps and a drain pause.
// ----------------------------------------------------------------------------
class access_time_board;
    typedef struct {
        logic [7:0]  req;
        logic [15:0] tag;
        logic [63:0] rt;
        logic        hold;
        logic [1:0]  status;
    } t_timing;

    // Configuration copy
    smcrq_pkg::t_mode mode;
    logic [8:0]  per;
    logic [31:0] llat, rlat;
    logic [15:0] lbw, rbw;

    // Channel state copy
    bit          ch_busy[8];
    logic [47:0] w_size[8][$];
    logic [7:0]  w_req[8][$];
    logic [15:0] w_tag[8][$];

    t_timing pending[$];
    int      errors;

    function new();
        mode = smcrq_pkg::MODE_NONE;
        per = 9'd1; llat = 32'd0; lbw = 16'd1; rlat = 32'd0; rbw = 16'd1;
        errors = 0;
        for (int i = 0; i < 8; i++) ch_busy[i] = 1'b0;
    endfunction

    function void write_reg(smcrq_pkg::t_reg_idx idx, logic [31:0] v);
        case (idx)
            smcrq_pkg::REG_MODE: mode = smcrq_pkg::t_mode'(v[1:0]);
            smcrq_pkg::REG_PER:  per  = v[8:0];
            smcrq_pkg::REG_LLAT: llat = v;
            smcrq_pkg::REG_LBW:  lbw  = v[15:0];
            smcrq_pkg::REG_RLAT: rlat = v;
            smcrq_pkg::REG_RBW:  rbw  = v[15:0];
            default: ;
        endcase
    endfunction

    function logic [63:0] calc_time(logic [31:0] lat, logic [15:0] gbps, logic [47:0] sz);
        logic [127:0] num, q;
        logic [127:0] den;
        logic [64:0]  sum;
        den = (gbps == 0 ? 128'd1 : 128'(gbps)) * 128'd1000000000;
        num = 128'(sz) * 128'd1000000000;
        q = num / den;
        if (q[127:64] != 0) return '1;
        sum = 65'(lat) + 65'(q[63:0]);
        return sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
    endfunction

    function int chan_of(logic [7:0] r);
        int p;
        if (mode == smcrq_pkg::MODE_POOL) return 0;
        p = (per == 0) ? 1 : int'(per);
        return (int'(r) / p < 8) ? int'(r) / p : 8;
    endfunction

    function void add_expect(logic [7:0] r, logic [15:0] t, logic [63:0] rt, bit h,
                             logic [1:0] s);
        t_timing e;
        e.req = r; e.tag = t; e.rt = rt; e.hold = h; e.status = s;
        pending = {pending, e};
    endfunction

    // Note an accepted word
    function void note_word(bit op, bit rem, logic [7:0] r, logic [47:0] sz, logic [15:0] t);
        int          ch;
        logic [47:0] q_sz;
        logic [7:0]  q_req;
        logic [15:0] q_tag;
        if (op == smcrq_pkg::OP_REQUEST) begin
            if (!rem) begin
                add_expect(r, t, calc_time(llat, lbw, sz), 1'b0, smcrq_pkg::ST_OK);
                return;
            end
            if (mode == smcrq_pkg::MODE_NONE) begin
                add_expect(r, t, 64'd0, 1'b0, smcrq_pkg::ST_NO_REMOTE);
                return;
            end
            if (mode == smcrq_pkg::MODE_NPU) begin
                add_expect(r, t, calc_time(rlat, rbw, sz), 1'b0, smcrq_pkg::ST_OK);
                return;
            end
            ch = chan_of(r);
            if (ch >= 8) begin
                add_expect(r, t, 64'd0, 1'b0, smcrq_pkg::ST_NODE_RANGE);
                return;
            end
            if (ch_busy[ch]) begin
                if (w_size[ch].size() >= 16) begin
                    add_expect(r, t, 64'd0, 1'b0, smcrq_pkg::ST_QUEUE_FULL);
                end else begin
                    w_size[ch] = {w_size[ch], sz};
                    w_req[ch]  = {w_req[ch], r};
                    w_tag[ch]  = {w_tag[ch], t};
                end
                return;
            end
            ch_busy[ch] = 1'b1;
            add_expect(r, t, calc_time(rlat, rbw, sz), 1'b1, smcrq_pkg::ST_OK);
            return;
        end
        if (mode != smcrq_pkg::MODE_NODE && mode != smcrq_pkg::MODE_POOL) return;
        ch = chan_of(r);
        if (ch >= 8) return;
        if (w_size[ch].size() == 0) begin
            ch_busy[ch] = 1'b0;
            return;
        end
        ch_busy[ch] = 1'b1;
        q_sz  = w_size[ch][0];
        q_req = w_req[ch][0];
        q_tag = w_tag[ch][0];
        w_size[ch].delete(0);
        w_req[ch].delete(0);
        w_tag[ch].delete(0);
        add_expect(q_req, q_tag, calc_time(rlat, rbw, q_sz), 1'b1, smcrq_pkg::ST_OK);
    endfunction

    // Check a result against the oldest expectation
    function void check_result(logic [7:0] r, logic [15:0] t, logic [63:0] rt, bit h,
                               logic [1:0] s);
        t_timing e;
        if (pending.size() == 0) begin
            $error("unexpected result req=%0d tag=%0d", r, t);
            errors++;
            return;
        end
        e = pending[0];
        pending.delete(0);
        if (r !== e.req) begin
            $error("dest_requester exp %0d got %0d", e.req, r); errors++;
        end
        if (t !== e.tag) begin
            $error("dest_tag exp %0d got %0d", e.tag, t); errors++;
        end
        if (rt !== e.rt) begin
            $error("runtime exp %0d got %0d", e.rt, rt); errors++;
        end
        if (h !== e.hold) begin
            $error("holds_channel exp %0d got %0d", e.hold, h); errors++;
        end
        if (s !== e.status) begin
            $error("status exp %0d got %0d", e.status, s); errors++;
        end
    endfunction
endclass

module testbench;
    import smcrq_pkg::*;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              psel = 0, penable = 0, pwrite = 0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              start = 0;
    logic              busy;
    logic              i_op = 0, i_is_remote = 0;
    logic [REQ_W-1:0]  i_requester = '0;
    logic [SIZE_W-1:0] i_tensor_size = '0;
    logic [TAG_W-1:0]  i_tag = '0;
    logic              o_result_valid;
    logic [REQ_W-1:0]  o_dest_requester;
    logic [TAG_W-1:0]  o_dest_tag;
    logic [RT_W-1:0]   o_runtime;
    logic              o_holds_channel;
    logic [1:0]        o_status;

    access_time_board board = new();
    int unsigned      cycles = 0;
    int               gap_pct = 0;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    shared_memory_channel_request_queue_core u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Sample results and watch the cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_result_valid)
            board.check_result(o_dest_requester, o_dest_tag, o_runtime,
                               o_holds_channel, o_status);
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= APB_AW'(idx) << 2; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.write_reg(idx, v);
    endtask

    // Drive one word; the block stays busy through the cycle after acceptance,
    // so the extra falling edge at the top costs no throughput
    task automatic send_word(t_op op, bit rem, logic [7:0] r, logic [47:0] sz,
                             logic [15:0] t);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) @(negedge i_clk);
        i_op <= op; i_is_remote <= rem; i_requester <= r; i_tensor_size <= sz; i_tag <= t;
        start <= 1;
        do @(posedge i_clk); while (busy);
        board.note_word(op, rem, r, sz, t);
        @(negedge i_clk);
        start <= 0;
    endtask

    // Wait for all expected words, then the latency tail
    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    function automatic logic [47:0] rand_size();
        case ($urandom_range(4))
            0: return 48'($urandom_range(4096));
            1: return '1;
            2: return 48'({$urandom, $urandom});
            default: return 48'($urandom);
        endcase
    endfunction

    task automatic config_all(t_mode m, int p, logic [31:0] ll, logic [15:0] lb,
                              logic [31:0] rl, logic [15:0] rb);
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_PER, 32'(p));
        write_reg(REG_LLAT, ll);
        write_reg(REG_LBW, 32'(lb));
        write_reg(REG_RLAT, rl);
        write_reg(REG_RBW, 32'(rb));
    endtask

    // Mostly requests, most of them remote, from few requesters, mixed with completions
    task automatic random_phase(int n);
        int k = 0;
        while (k < n) begin
            logic [7:0] r = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
            if ($urandom_range(99) < 35)
                send_word(OP_COMPLETE, 1'($urandom), r, rand_size(), 16'($urandom));
            else
                send_word(OP_REQUEST, $urandom_range(9) < 7, r, rand_size(), 16'($urandom));
            k++;
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: local extremes and remote words at reset values
        send_word(OP_REQUEST, 1'b0, 8'd0, 48'd0, 16'd0);
        send_word(OP_REQUEST, 1'b0, 8'hFF, '1, 16'hFFFF);
        send_word(OP_REQUEST, 1'b1, 8'd3, 48'd100, 16'd1);
        send_word(OP_COMPLETE, 1'b0, 8'd0, 48'd0, 16'd2);
        drain();
        config_all(MODE_NODE, 0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
        send_word(OP_REQUEST, 1'b0, 8'd1, '1, 16'd3);
        send_word(OP_REQUEST, 1'b1, 8'd200, 48'd5, 16'd4);
        send_word(OP_REQUEST, 1'b1, 8'd2, '1, 16'd5);
        for (int i = 0; i < 17; i++)
            send_word(OP_REQUEST, 1'b1, 8'd2, 48'(i * 1000), 16'(10 + i));
        send_word(OP_COMPLETE, 1'b1, 8'd2, 48'd0, 16'd0);
        send_word(OP_COMPLETE, 1'b0, 8'd255, 48'd0, 16'd0);
        drain();
        write_reg(REG_MODE, 32'(MODE_NPU));
        send_word(OP_REQUEST, 1'b1, 8'd7, 48'd123456, 16'd30);
        send_word(OP_COMPLETE, 1'b0, 8'd2, 48'd0, 16'd0);
        drain();

        // Random phases over several settings
        gap_pct = 12;
        config_all(MODE_NODE, 4, 32'd10, 16'd1, 32'd1000, 16'd3);
        random_phase(260);
        drain();
        config_all(MODE_POOL, 256, 32'd0, 16'd64, 32'hFFFF_FFFF, 16'd65535);
        random_phase(260);
        drain();
        gap_pct = 45;
        config_all(MODE_NODE, 1, $urandom, 16'($urandom_range(1, 65535)), $urandom, 16'd0);
        random_phase(260);
        drain();
        config_all(MODE_NONE, 255, $urandom, 16'd7, $urandom, 16'd9);
        random_phase(120);
        drain();
        gap_pct = 0;
        config_all(MODE_NPU, 32, $urandom, 16'd100, $urandom, 16'd200);
        random_phase(100);
        drain();
        config_all(MODE_NODE, 2, $urandom, 16'd1, 32'd5, 16'd25);
        random_phase(260);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
